>>> hdl/url_percent_decoder_core_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef URL_PERCENT_DECODER_CORE_ASSERT_SVH
`define URL_PERCENT_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define UPD_ASSERT(lbl, clock, reset, cond) \
  lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error("upd assertion failed");

// Checks that a condition is followed by another in the next cycle.
`define UPD_ASSERT_NEXT(lbl, clock, reset, cond, result) \
  lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (result)) \
    else $error("upd assertion failed");

`else

`define UPD_ASSERT(lbl, clock, reset, cond)
`define UPD_ASSERT_NEXT(lbl, clock, reset, cond, result)

`endif

`endif

>>> hdl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Work handed from the front to the back. A pair first gives a literal
  // percent sign and then data.
  typedef struct packed {
    logic       pair;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic second;
  } back_status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end
      return d[3:0];
    end
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

>>> hdl/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      count <= count_next;
    end
  end

endmodule

>>> hdl/upd_front.sv
`timescale 1ns / 1ps

module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          full,
  output logic          push,
  output upd_pkg::cmd_t push_cmd
);

  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic       accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    phase_next    = phase;
    push          = 1'b0;
    push_cmd.pair = 1'b0;
    push_cmd.data = plain_byte(in_byte);
    push_cmd.last = in_last;
    case (phase)
      PH_PCT: begin
        if (in_last) begin
          push_cmd.pair = 1'b1;
          push          = accept;
          phase_next    = PH_IDLE;
        end else begin
          phase_next = PH_DIG;
        end
      end
      PH_DIG: begin
        push_cmd.data = {hex_value(held_digit), hex_value(in_byte)};
        push          = accept;
        phase_next    = PH_IDLE;
      end
      default: begin
        if (in_byte == CH_PERCENT && !in_last) begin
          phase_next = PH_PCT;
        end else begin
          push       = accept;
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_PCT) begin
      held_digit <= in_byte;
    end
  end

endmodule

>>> hdl/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  upd_pkg::cmd_t         head,
  output upd_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  import upd_pkg::*;

  logic load;
  logic second;
  logic first_of_pair;

  assign load          = !out_valid || !out_stall;
  assign first_of_pair = head.pair && !second;
  assign status.pop    = load && !empty && !first_of_pair;
  assign status.second = second;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        second <= first_of_pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (first_of_pair) begin
        out_byte <= CH_PERCENT;
        out_last <= 1'b0;
      end else begin
        out_byte <= head.data;
        out_last <= head.last;
      end
    end
  end

endmodule

>>> hdl/url_percent_decoder_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  in_byte, in_last
// output   out        out_valid/out_stall out_byte, out_last
//
// One byte is taken per cycle while the command queue has room.
// At the earliest, out_valid rises once the byte that completes a result has passed the queue and the output register.
// A percent sign one byte before the end of a string gives two results: a literal percent sign, then the last byte.
// Synchronous active-high reset empties the queue and clears any pending escape.
// A stalled output lets the queue fill, after which in_stall rises.

module url_percent_decoder_core #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  import upd_pkg::*;

  `include "url_percent_decoder_core_assert.svh"

  logic         push;
  cmd_t         push_cmd;
  cmd_t         head;
  logic         empty;
  logic         full;
  back_status_t status;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  upd_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (status.pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  `UPD_ASSERT(a_push_not_full, clk, rst, !(push && full))
  `UPD_ASSERT(a_pop_not_empty, clk, rst, !(status.pop && empty))
  `UPD_ASSERT(a_pair_held, clk, rst, !(status.second && empty))
  `UPD_ASSERT_NEXT(a_pair_tail, clk, rst, status.second && !out_stall, out_valid && !status.second)

endmodule
